[rtl/vph_pkg.sv]
// vph_pkg: shared types, widths, register codes and helpers of the voxel projection histogram
// no dependencies
`default_nettype none

package vph_pkg;

  // sizes
  localparam int MAX_BINS   = 64;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int BINCNT_W   = 7;
  localparam int POS_W      = 8;
  localparam int GRID_W     = 9;
  localparam int WEIGHT_W   = 32;
  localparam int SPACING_W  = 32;
  localparam int SAMPLE_W   = 24;
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int SUM_W      = 56;
  localparam int COUNT_W    = 25;
  localparam int DIST_W     = 38;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = WEIGHT_W + POS_W + 1;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [GRID_W-1:0]   GRID_LIM  = GRID_W'(1 << POS_W);
  localparam logic [BINCNT_W-1:0] BIN_LIM   = BINCNT_W'(MAX_BINS);
  localparam logic [SUM_W-1:0]    SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SPACING = 3'd7;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_x;
    logic signed [WEIGHT_W-1:0] weight_y;
    logic signed [WEIGHT_W-1:0] weight_z;
    logic [GRID_W-1:0]          grid_x;
    logic [GRID_W-1:0]          grid_y;
    logic [GRID_W-1:0]          grid_z;
    logic [BINCNT_W-1:0]        bin_count;
    logic [SPACING_W-1:0]       bin_spacing;
  } cfg_regs_t;

  // one classified sample on its way to the bin update
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [SQ_W-1:0]  sq;
    logic             sat;
    logic             done;
  } fifo_entry_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } bin_entry_t;

  typedef struct packed {
    logic readout;
    logic pop;
    logic range_flag;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } back_state_t;

  function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] g);
    logic [GRID_W-1:0] r;
    if (g == '0) begin
      r = GRID_W'(1);
    end else if (g > GRID_LIM) begin
      r = GRID_LIM;
    end else begin
      r = g;
    end
    return r;
  endfunction

  function automatic logic [BINCNT_W-1:0] eff_bins(input logic [BINCNT_W-1:0] c);
    logic [BINCNT_W-1:0] r;
    if (c == '0) begin
      r = BINCNT_W'(1);
    end else if (c > BIN_LIM) begin
      r = BIN_LIM;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/vph_in_if.sv]
// vph_in_if: sample channel, valid/ready with one signed sample
// depends on vph_pkg
`default_nettype none

interface vph_in_if;
  import vph_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[rtl/vph_out_if.sv]
// vph_out_if: result channel, valid/ready with one histogram bin per transfer
// depends on vph_pkg
`default_nettype none

interface vph_out_if;
  import vph_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BIN_W-1:0]     bin_index;
  logic [DIST_W-1:0]    distance;
  logic [SUM_W-1:0]     square_sum;
  logic [COUNT_W-1:0]   hit_count;
  logic                 out_of_range;
  logic                 last;

  modport source (output valid, output bin_index, output distance, output square_sum,
                  output hit_count, output out_of_range, output last, input ready);
  modport sink   (input valid, input bin_index, input distance, input square_sum,
                  input hit_count, input out_of_range, input last, output ready);
endinterface

`default_nettype wire

[rtl/vph_cfg_if.sv]
// vph_cfg_if: register write channel, valid/ready with index and data
// depends on vph_pkg
`default_nettype none

interface vph_cfg_if;
  import vph_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/vph_front.sv]
// vph_front: voxel counters, projection, rounding and bin classification
// depends on vph_pkg, vph_in_if; feeds vph_fifo
`default_nettype none

module vph_front (
  input  wire logic                clk,
  input  wire logic                rst,
  vph_in_if.sink                   samples,
  input  vph_pkg::cfg_regs_t       cfg_regs,
  input  wire logic                fifo_full,
  output logic                     push,
  output vph_pkg::fifo_entry_t     push_data
);
  import vph_pkg::*;

  localparam int RSUM_W = ACC_W - 1;
  localparam int R_W    = RSUM_W - FRAC_W;
  localparam logic [RSUM_W-1:0]      HALF     = RSUM_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] NEG_HALF = ACC_W'(-(2 ** (FRAC_W - 1)));

  logic [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [POS_W-1:0] pos_x_next, pos_y_next, pos_z_next;
  logic             wrap_all;

  // stage 1: products and square
  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_px, s1_py, s1_pz;
  logic [SQ_W-1:0]          s1_sq;
  logic                     s1_done;

  // stage 2: projection sum
  logic                     s2_valid;
  logic signed [ACC_W-1:0]  s2_acc;
  logic [SQ_W-1:0]          s2_sq;
  logic                     s2_done;

  logic                     s2_ready;
  logic                     accept;
  logic signed [SQ_W-1:0]   sq_full;

  logic [RSUM_W-1:0]        rsum;
  logic [R_W-1:0]           r;
  logic [R_W-1:0]           n_ext;
  logic [BINCNT_W-1:0]      n_eff;
  logic [BINCNT_W-1:0]      n_top;
  logic [BIN_W-1:0]         bin;
  logic                     sat;

  assign s2_ready      = !s2_valid || !fifo_full;
  assign samples.ready = !s1_valid || s2_ready;
  assign accept        = samples.valid && samples.ready;
  assign push          = s2_valid && !fifo_full;
  assign sq_full       = samples.sample * samples.sample;

  // raster advance, z fastest
  always_comb begin
    logic [GRID_W-1:0] z1, y1, x1;
    z1 = GRID_W'(pos_z) + GRID_W'(1);
    y1 = GRID_W'(pos_y) + GRID_W'(1);
    x1 = GRID_W'(pos_x) + GRID_W'(1);
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = z1[POS_W-1:0];
    wrap_all   = 1'b0;
    if (z1 >= eff_grid(cfg_regs.grid_z)) begin
      pos_z_next = '0;
      pos_y_next = y1[POS_W-1:0];
      if (y1 >= eff_grid(cfg_regs.grid_y)) begin
        pos_y_next = '0;
        pos_x_next = x1[POS_W-1:0];
        if (x1 >= eff_grid(cfg_regs.grid_x)) begin
          pos_x_next = '0;
          wrap_all   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pos_x    <= '0;
      pos_y    <= '0;
      pos_z    <= '0;
    end else begin
      if (samples.ready) s1_valid <= samples.valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (accept) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
        pos_z <= pos_z_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= $signed({1'b0, pos_x}) * cfg_regs.weight_x;
      s1_py   <= $signed({1'b0, pos_y}) * cfg_regs.weight_y;
      s1_pz   <= $signed({1'b0, pos_z}) * cfg_regs.weight_z;
      s1_sq   <= sq_full;
      s1_done <= wrap_all;
    end
    if (s2_ready && s1_valid) begin
      s2_acc  <= ACC_W'(s1_px) + ACC_W'(s1_py) + ACC_W'(s1_pz);
      s2_sq   <= s1_sq;
      s2_done <= s1_done;
    end
  end

  // round half away from zero, then clamp into 0..n-1
  assign n_eff = eff_bins(cfg_regs.bin_count);
  assign n_top = n_eff - BINCNT_W'(1);
  assign n_ext = R_W'(n_eff);
  assign rsum  = s2_acc[RSUM_W-1:0] + HALF;
  assign r     = rsum[RSUM_W-1:FRAC_W];

  always_comb begin
    bin = '0;
    sat = 1'b0;
    if (s2_acc[ACC_W-1]) begin
      sat = (s2_acc < NEG_HALF + ACC_W'(1));
    end else if (r == n_ext) begin
      bin = n_top[BIN_W-1:0];
    end else if (r > n_ext) begin
      bin = n_top[BIN_W-1:0];
      sat = 1'b1;
    end else begin
      bin = r[BIN_W-1:0];
    end
  end

  assign push_data.bin  = bin;
  assign push_data.sq   = s2_sq;
  assign push_data.sat  = sat;
  assign push_data.done = s2_done;

endmodule

`default_nettype wire

[rtl/vph_fifo.sv]
// vph_fifo: short queue of classified samples between front and back
// depends on vph_pkg
`default_nettype none

module vph_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  vph_pkg::fifo_entry_t     push_data,
  output logic                     full,
  input  wire logic                pop,
  output vph_pkg::fifo_entry_t     head,
  output logic                     not_empty
);
  import vph_pkg::*;

  fifo_entry_t             slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_PTR_W:0]     count;

  assign full      = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      if (push && !pop) begin
        count <= count + (FIFO_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

[rtl/vph_back.sv]
// vph_back: bin read-modify-write with forwarding, and the end-of-frame readout
// depends on vph_pkg, vph_out_if; pops from vph_fifo
`default_nettype none

module vph_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  vph_pkg::cfg_regs_t       cfg_regs,
  input  vph_pkg::fifo_entry_t     head,
  input  wire logic                not_empty,
  output logic                     pop,
  vph_out_if.source                results,
  output vph_pkg::back_stat_t      status
);
  import vph_pkg::*;

  back_state_t state, state_next;

  bin_entry_t          mem [MAX_BINS];
  logic [MAX_BINS-1:0] bin_valid;
  bin_entry_t          mem_q;
  logic                q_valid;
  logic [BIN_W-1:0]    rd_addr;

  // update stage
  logic             w_valid;
  logic [BIN_W-1:0] w_bin;
  logic [SQ_W-1:0]  w_sq;
  logic             w_sat;

  // last written entry, covers a read that raced its write
  logic             fwd_valid;
  logic [BIN_W-1:0] fwd_bin;
  bin_entry_t       fwd_data;

  bin_entry_t       base;
  bin_entry_t       updated;
  logic [SUM_W:0]   sum_wide;

  logic [BIN_W-1:0]    rd_idx;
  logic [BINCNT_W-1:0] n_top;
  logic                range_flag;
  logic                out_last;

  // fsm controls
  logic sel_idx;
  logic start_read;
  logic load_out;
  logic step_idx;
  logic finish;

  assign n_top = eff_bins(cfg_regs.bin_count) - BINCNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: if (pop && head.done) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_READ;
      ST_READ:  state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_SEND;
      ST_SEND: begin
        if (results.ready) state_next = out_last ? ST_ACCUM : ST_READ;
      end
      default:  state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    sel_idx    = 1'b0;
    start_read = 1'b0;
    load_out   = 1'b0;
    step_idx   = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_ACCUM: pop = not_empty;
      ST_DRAIN: start_read = 1'b1;
      ST_READ:  sel_idx = 1'b1;
      ST_LOAD:  load_out = 1'b1;
      ST_SEND: begin
        finish   = results.ready && out_last;
        step_idx = results.ready && !out_last;
      end
      default: ;
    endcase
  end

  assign results.valid = (state == ST_SEND);
  assign rd_addr       = sel_idx ? rd_idx : head.bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACCUM;
      w_valid    <= 1'b0;
      fwd_valid  <= 1'b0;
      bin_valid  <= '0;
      range_flag <= 1'b0;
      rd_idx     <= '0;
    end else begin
      state     <= state_next;
      w_valid   <= pop;
      fwd_valid <= w_valid;
      if (w_valid) begin
        bin_valid[w_bin] <= 1'b1;
        if (w_sat) range_flag <= 1'b1;
      end
      if (finish) bin_valid <= '0;
      if (start_read) begin
        rd_idx <= '0;
      end else if (step_idx) begin
        rd_idx <= rd_idx + BIN_W'(1);
      end
    end
  end

  // bin store, registered read
  always_ff @(posedge clk) begin
    mem_q   <= mem[rd_addr];
    q_valid <= bin_valid[rd_addr];
    if (w_valid) mem[w_bin] <= updated;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_bin <= head.bin;
      w_sq  <= head.sq;
      w_sat <= head.sat;
    end
    if (w_valid) begin
      fwd_bin  <= w_bin;
      fwd_data <= updated;
    end
  end

  always_comb begin
    if (fwd_valid && fwd_bin == w_bin) begin
      base = fwd_data;
    end else if (q_valid) begin
      base = mem_q;
    end else begin
      base = '0;
    end
    sum_wide = (SUM_W + 1)'(base.sum) + (SUM_W + 1)'(w_sq);
    updated.sum   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    updated.count = (base.count == COUNT_MAX) ? base.count : base.count + COUNT_W'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      results.bin_index    <= rd_idx;
      results.distance     <= DIST_W'(rd_idx) * DIST_W'(cfg_regs.bin_spacing);
      results.square_sum   <= q_valid ? mem_q.sum : '0;
      results.hit_count    <= q_valid ? mem_q.count : '0;
      results.out_of_range <= range_flag;
      results.last         <= (BINCNT_W'(rd_idx) == n_top);
      out_last             <= (BINCNT_W'(rd_idx) == n_top);
    end
  end

  assign status.readout    = (state != ST_ACCUM);
  assign status.pop        = pop;
  assign status.range_flag = range_flag;

endmodule

`default_nettype wire

[rtl/voxel_projection_histogram.sv]
// voxel_projection_histogram: top level, configuration registers, front, queue and back
// depends on vph_pkg, vph_in_if, vph_out_if, vph_cfg_if, vph_front, vph_fifo, vph_back
//
// Usage:
//   samples: one signed 24-bit sample per transfer, x-major raster order, z fastest.
//   The block keeps its own voxel counters; the sample that completes the grid
//   triggers a readout of bin_count (clamped to 1..64) bins on results, bin 0 first, last set on the
//   final bin. Each bin carries its distance, square sum, point count and the
//   sticky out_of_range flag. Bins are cleared after the readout.
//   cfg: register writes by index, always ready; write only while idle.
// Timing:
//   Samples are taken one per cycle while the queue is not full. A sample passes
//   two front stages (products, then projection sum) and the four-entry queue
//   before its bin update, a read-modify-write with one-entry forwarding in the back.
//   After the last sample is popped the back passes drain, read and load states,
//   then offers the first bin; each bin takes a registered bin store read, an output
//   load and a transfer held while results.ready is low. During readout the front
//   keeps taking samples of the next frame until its two stages and the queue are full.
// Reset: rst clears counters, flag and the bin valid bits at once; registers take
//   their reset values. No clearing pass is needed.
`default_nettype none

module voxel_projection_histogram (
  input  wire logic clk,
  input  wire logic rst,
  vph_cfg_if.sink   cfg,
  vph_in_if.sink    samples,
  vph_out_if.source results
);
  import vph_pkg::*;

  cfg_regs_t   cfg_regs;
  fifo_entry_t push_data;
  fifo_entry_t head;
  logic        push;
  logic        fifo_full;
  logic        not_empty;
  logic        pop;
  back_stat_t  back_stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.weight_x    <= '0;
      cfg_regs.weight_y    <= '0;
      cfg_regs.weight_z    <= '0;
      cfg_regs.grid_x      <= GRID_LIM;
      cfg_regs.grid_y      <= GRID_LIM;
      cfg_regs.grid_z      <= GRID_LIM;
      cfg_regs.bin_count   <= BIN_LIM;
      cfg_regs.bin_spacing <= SPACING_W'(1 << FRAC_W);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WEIGHT_X:    cfg_regs.weight_x    <= cfg.data;
        REG_WEIGHT_Y:    cfg_regs.weight_y    <= cfg.data;
        REG_WEIGHT_Z:    cfg_regs.weight_z    <= cfg.data;
        REG_GRID_X:      cfg_regs.grid_x      <= cfg.data[GRID_W-1:0];
        REG_GRID_Y:      cfg_regs.grid_y      <= cfg.data[GRID_W-1:0];
        REG_GRID_Z:      cfg_regs.grid_z      <= cfg.data[GRID_W-1:0];
        REG_BIN_COUNT:   cfg_regs.bin_count   <= cfg.data[BINCNT_W-1:0];
        REG_BIN_SPACING: cfg_regs.bin_spacing <= cfg.data[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  vph_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg_regs  (cfg_regs),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  vph_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  vph_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .results   (results),
    .status    (back_stat)
  );

  // the final bin of a readout is always the top bin in use
  a_last_is_top: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.last |->
      BINCNT_W'(results.bin_index) == eff_bins(cfg_regs.bin_count) - BINCNT_W'(1))
    else $error("last flag on a bin other than the top bin");

  // no bin update may start while the histogram is being read out
  a_no_pop_in_readout: assert property (@(posedge clk) disable iff (rst)
    back_stat.readout |-> !back_stat.pop)
    else $error("queue popped during readout");

  // the range flag only clears through reset
  a_flag_sticky: assert property (@(posedge clk)
    $fell(back_stat.range_flag) |-> $past(rst))
    else $error("range flag cleared without reset");

endmodule

`default_nettype wire
